// ----- hw/rtl/abre_pkg.sv -----
// Package for the adaptive binary range encoder: request and result word types,
// controller/datapath command and status structs, coder constants.
// No dependencies.
package abre_pkg;

    localparam int PROB_DEPTH_DEF = 2048;

    localparam logic [1:0] REQ_MODEL  = 2'd0;
    localparam logic [1:0] REQ_DIRECT = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    localparam logic [10:0] PROB_START   = 11'd1024;
    localparam logic [31:0] RANGE_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP_LIMIT    = 32'h0100_0000;
    localparam logic [31:0] EMIT_LIMIT   = 32'hFF00_0000;
    localparam logic [31:0] PENDING_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] PENDING_INIT = 32'd1;
    localparam logic [4:0]  DIRECT_MAX   = 5'd26;
    localparam logic [2:0]  MAX_RES      = 3'd5;
    localparam logic [2:0]  FLUSH_LAST   = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] ctx_index;
        logic        bit_value;
        logic [25:0] direct_value;
        logic [4:0]  direct_count;
    } req_t;

    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [31:0] run_count;
        logic [7:0]  run_byte;
        logic        last;
    } res_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic rd;
        logic mul;
        logic upd;
        logic dir_step;
        logic shift;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic norm_upd;
        logic norm_dir;
        logic cnt_zero;
        logic shift_ok;
        logic fin_ok;
    } stat_t;

endpackage

// ----- hw/rtl/abre_ctrl.sv -----
// Sequencing controller for the range encoder: clearing sweep, per-request
// step sequence, flush shift count. Depends on abre_pkg.
module abre_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_type,
    output logic                req_ready,
    input  abre_pkg::stat_t     stat,
    output abre_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_UPD   = 8'b0001_0000,
        S_DIR   = 8'b0010_0000,
        S_SHIFT = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  fl_cnt_reg, fl_cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        fl_cnt_next = fl_cnt_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    mode_next   = req_type;
                    fl_cnt_next = '0;
                    case (req_type)
                        abre_pkg::REQ_MODEL:  state_next = S_READ;
                        abre_pkg::REQ_DIRECT: state_next = S_DIR;
                        abre_pkg::REQ_FLUSH:  state_next = S_SHIFT;
                        default:              state_next = S_FIN;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.norm_upd ? S_SHIFT : S_FIN;
            end
            S_DIR:
            begin
                if (stat.cnt_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.dir_step = 1'b1;
                    if (stat.norm_dir)
                        state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // stall here while a word cannot be pushed to the output
                if (stat.shift_ok)
                begin
                    cmd.shift = 1'b1;
                    case (mode_reg)
                        abre_pkg::REQ_FLUSH:
                        begin
                            if (fl_cnt_reg == abre_pkg::FLUSH_LAST)
                                state_next = S_FIN;
                            else
                                fl_cnt_next = fl_cnt_reg + 3'd1;
                        end
                        abre_pkg::REQ_DIRECT: state_next = S_DIR;
                        default:              state_next = S_FIN;
                    endcase
                end
            end
            S_FIN:
            begin
                if (stat.fin_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            mode_reg   <= abre_pkg::REQ_MODEL;
            fl_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            fl_cnt_reg <= fl_cnt_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("controller still ready after taking a word");

    a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && mode_reg == abre_pkg::REQ_FLUSH)
            |-> fl_cnt_reg <= abre_pkg::FLUSH_LAST)
        else $error("flush shift count overran");

endmodule

// ----- hw/rtl/abre_dp.sv -----
// Datapath for the range encoder: coder registers, probability memory with
// clearing sweep, low-shift carry logic, hold and output word registers.
// Depends on abre_pkg.
module abre_dp #(
    parameter int PROB_DEPTH = abre_pkg::PROB_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  abre_pkg::req_t   req,
    input  abre_pkg::cmd_t   cmd,
    output abre_pkg::stat_t  stat,
    output abre_pkg::res_t   res,
    output logic             res_valid,
    input  logic             res_ready
);

    localparam int              IDX_W    = $clog2(PROB_DEPTH);
    localparam int              RECIP_W  = 33 - IDX_W;
    localparam longint unsigned RECIP    = 64'h1_0000_0000 / PROB_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [31:0]     DEPTH_V  = 32'(PROB_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PROB_DEPTH - 1);

    logic [10:0] prob_mem [PROB_DEPTH];

    // coder state
    logic [32:0] low_reg, low_next;
    logic [31:0] range_reg, range_next;
    logic [7:0]  cached_reg, cached_next;
    logic [31:0] pending_reg, pending_next;

    // request item and step registers
    logic [10:0] ctx_reg;
    logic [10:0] q_reg;
    logic        bit_reg;
    logic [25:0] dval_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg;
    logic [10:0] p_reg;
    logic [31:0] bound_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [2:0]  res_cnt_reg, res_cnt_next;

    abre_pkg::res_t hold_reg, hold_next;
    logic           hold_v_reg, hold_v_next;
    abre_pkg::res_t out_reg, out_next;
    logic           out_v_reg, out_v_next;

    // context reduction: quotient estimate at load, remainder fix-up on read
    logic [10+RECIP_W:0] q_prod;
    logic [31:0]         r_full;
    logic [31:0]         r_corr;
    logic [IDX_W-1:0]    rd_addr;

    assign q_prod = {{RECIP_W{1'b0}}, req.ctx_index} * {11'd0, RECIP_V};
    assign r_full = {21'd0, ctx_reg} - ({21'd0, q_reg} * DEPTH_V);
    assign r_corr = (r_full >= DEPTH_V) ? r_full - DEPTH_V : r_full;
    assign rd_addr = r_corr[IDX_W-1:0];

    // modeled bit arithmetic
    logic [31:0] bound_next;
    logic [10:0] p_new;
    logic [31:0] range_upd;
    logic [32:0] low_upd;
    logic        norm_upd;

    assign bound_next = {11'd0, range_reg[31:11]} * {21'd0, p_reg};

    always_comb
    begin
        if (bit_reg)
        begin
            p_new     = p_reg - (p_reg >> 5);
            range_upd = range_reg - bound_reg;
            low_upd   = low_reg + {1'b0, bound_reg};
        end
        else
        begin
            p_new     = p_reg + 11'((12'd2048 - {1'b0, p_reg}) >> 5);
            range_upd = bound_reg;
            low_upd   = low_reg;
        end
    end

    assign norm_upd = range_upd < abre_pkg::TOP_LIMIT;

    // direct bit arithmetic
    logic [31:0] range_h;
    logic        dbit;
    logic [32:0] low_dir;
    logic        norm_dir;

    assign range_h  = {1'b0, range_reg[31:1]};
    assign dbit     = dval_reg[5'(cnt_reg - 5'd1)];
    assign low_dir  = dbit ? low_reg + {1'b0, range_h} : low_reg;
    assign norm_dir = range_h < abre_pkg::TOP_LIMIT;

    // low shift
    logic [31:0] lo32;
    logic        carry;
    logic        emit_cond;
    logic        emit_take;
    logic        push_mid;
    logic        push_fin;
    logic        out_free;
    abre_pkg::res_t group;

    assign lo32      = low_reg[31:0];
    assign carry     = low_reg[32];
    assign emit_cond = (lo32 < abre_pkg::EMIT_LIMIT) || carry;
    assign emit_take = cmd.shift && emit_cond && (res_cnt_reg < abre_pkg::MAX_RES);
    assign push_mid  = emit_take && hold_v_reg;
    assign push_fin  = cmd.finish && hold_v_reg;
    assign out_free  = !out_v_reg || res_ready;

    always_comb
    begin
        group.lead_byte = cached_reg + {7'd0, carry};
        group.run_count = pending_reg - 32'd1;
        group.run_byte  = 8'hFF + {7'd0, carry};
        group.last      = 1'b0;
    end

    always_comb
    begin
        low_next     = low_reg;
        range_next   = range_reg;
        cached_next  = cached_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        if (cmd.load)
            cnt_next = (req.direct_count > abre_pkg::DIRECT_MAX) ?
                       abre_pkg::DIRECT_MAX : req.direct_count;
        if (cmd.upd)
        begin
            low_next   = low_upd;
            range_next = norm_upd ? {range_upd[23:0], 8'h00} : range_upd;
        end
        if (cmd.dir_step)
        begin
            low_next   = low_dir;
            range_next = norm_dir ? {range_h[23:0], 8'h00} : range_h;
            cnt_next   = cnt_reg - 5'd1;
        end
        if (cmd.shift)
        begin
            if (emit_cond)
            begin
                cached_next  = lo32[31:24];
                pending_next = 32'd1;
            end
            else if (pending_reg != abre_pkg::PENDING_MAX)
                pending_next = pending_reg + 32'd1;
            low_next = {1'b0, lo32[23:0], 8'h00};
        end
    end

    always_comb
    begin
        hold_next    = hold_reg;
        hold_v_next  = hold_v_reg;
        out_next     = out_reg;
        out_v_next   = out_v_reg;
        res_cnt_next = res_cnt_reg;
        if (cmd.load)
            res_cnt_next = '0;
        if (push_mid || push_fin)
        begin
            out_next      = hold_reg;
            out_next.last = push_fin;
            out_v_next    = 1'b1;
        end
        else if (res_ready)
            out_v_next = 1'b0;
        if (emit_take)
        begin
            hold_next    = group;
            hold_v_next  = 1'b1;
            res_cnt_next = res_cnt_reg + 3'd1;
        end
        else if (push_fin)
            hold_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg      <= '0;
            range_reg    <= abre_pkg::RANGE_INIT;
            cached_reg   <= '0;
            pending_reg  <= abre_pkg::PENDING_INIT;
            cnt_reg      <= '0;
            clr_addr_reg <= '0;
            res_cnt_reg  <= '0;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            low_reg     <= low_next;
            range_reg   <= range_next;
            cached_reg  <= cached_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            res_cnt_reg <= res_cnt_next;
            hold_v_reg  <= hold_v_next;
            out_v_reg   <= out_v_next;
            if (cmd.clear)
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ctx_reg  <= req.ctx_index;
            q_reg    <= 11'(q_prod >> 32);
            bit_reg  <= req.bit_value;
            dval_reg <= req.direct_value;
        end
        if (cmd.mul)
            bound_reg <= bound_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    // probability memory: one write port (sweep or update), one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            prob_mem[clr_addr_reg] <= abre_pkg::PROB_START;
        else if (cmd.upd)
            prob_mem[idx_reg] <= p_new;
        if (cmd.rd)
        begin
            p_reg   <= prob_mem[rd_addr];
            idx_reg <= rd_addr;
        end
    end

    always_comb
    begin
        stat.clear_last = (clr_addr_reg == IDX_LAST);
        stat.norm_upd   = norm_upd;
        stat.norm_dir   = norm_dir;
        stat.cnt_zero   = (cnt_reg == 5'd0);
        stat.shift_ok   = !(emit_cond && (res_cnt_reg < abre_pkg::MAX_RES) && hold_v_reg)
                          || out_free;
        stat.fin_ok     = !hold_v_reg || out_free;
    end

    assign res       = out_reg;
    assign res_valid = out_v_reg;

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_mid || push_fin) |-> out_free)
        else $error("output word overwritten before it was taken");

    a_range_normalised: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd || cmd.dir_step) |=> range_reg[31:24] != 8'd0)
        else $error("range left below the top limit after a coding step");

    a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> pending_reg != 32'd0)
        else $error("pending count dropped to zero after a low shift");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_take |=> res_cnt_reg <= abre_pkg::MAX_RES && hold_v_reg)
        else $error("emitted group not held or result count overran");

endmodule

// ----- hw/rtl/adaptive_binary_range_encoder.sv -----
// Top level of the adaptive binary range encoder: joins the controller and the
// datapath. Depends on abre_pkg, abre_ctrl, abre_dp.
//
// Usage: one request word enters on req/req_valid/req_ready and causes zero to
// five result words on res/res_valid/res_ready. Each result word is one byte
// group: a lead byte followed by run_count copies of run_byte. The final word
// of a request carries last; a request that emits nothing gives no word.
// Requests are handled one at a time; req_ready is high only while idle.
// Steps per request:
//   modeled bit  memory read, multiply, update, a low shift if needed, finish
//   direct bits  one step per bit, a shift after any normalising step, finish
//   flush        five low shifts, then finish
// A result word appears in the cycle after the next emitting shift, or in the
// cycle after the finishing step for the last one; one word is held internally
// so the last flag can be set, the other sits in the output register.
// Reset clears the coder state and then sweeps the whole probability memory,
// one entry per cycle, before the first request is taken.
// While res_ready is low and both word registers are full, the sequencer
// holds at the next emitting shift or at the finishing step; no word is lost
// or repeated.
module adaptive_binary_range_encoder #(
    parameter int PROB_DEPTH = abre_pkg::PROB_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  abre_pkg::req_t  req,
    input  logic            req_valid,
    output logic            req_ready,
    output abre_pkg::res_t  res,
    output logic            res_valid,
    input  logic            res_ready
);

    abre_pkg::cmd_t  cmd;
    abre_pkg::stat_t stat;

    abre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    abre_dp #(
        .PROB_DEPTH (PROB_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

endmodule
